// ===== rtl/srrip_pkg.sv =====
// ----------------------------------------------------------------------------
// srrip_pkg
// Shared types and constants for the SHiP-assisted SRRIP replacement unit.
// ----------------------------------------------------------------------------
package srrip_pkg;

   // Re-reference prediction values and reuse counter limits
   localparam logic [1:0] RRPV_MAX     = 2'd3;
   localparam logic [1:0] CTR_MAX      = 2'd3;
   localparam logic [1:0] CTR_STRONG   = 2'd2;
   localparam logic [1:0] MEDIUM_RESET = 2'd2;

   // PC hash shifts
   localparam int HASH_SHIFT_A = 13;
   localparam int HASH_SHIFT_B = 23;

   // Request kinds carried in tuser
   localparam logic FUNC_VICTIM = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   // Main sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_SET,
      ST_TRAIN,
      ST_INSTALL
   } state_type;

   // Commands to the reuse counter table
   typedef struct packed {
      logic clear;     // write zero at the sweep address
      logic rd_old;    // read counter of the evicted line's signature
      logic train;     // write trained counter, read new signature's counter
      logic train_up;  // evicted line was reused: count up
   } ctr_cmd_type;

endpackage

// ===== rtl/srrip_mod_unit.sv =====
// ----------------------------------------------------------------------------
// srrip_mod_unit
// Remainder of an unsigned value by a constant. Powers of two (and moduli
// above the input range) are masked into the result register at start;
// others are reduced one hex digit per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module srrip_mod_unit #(
   parameter int IN_W  = 11,
   parameter int MOD   = 2048,
   parameter int OUT_W = ($clog2(MOD) > 0) ? $clog2(MOD) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [IN_W-1:0]  value,
   output logic [OUT_W-1:0] rem,
   output logic             done
);

   localparam bit POW2 = ((MOD & (MOD - 1)) == 0);
   localparam bit FAST = POW2 || ((IN_W < 17) && (MOD >= (32'd1 << IN_W)));

   logic [OUT_W-1:0] rem_ff;
   logic             vld_ff;

   assign rem  = rem_ff;
   assign done = vld_ff;

   generate
      if (FAST) begin : g_fast
         localparam logic [OUT_W-1:0] MASK = POW2 ? OUT_W'(MOD - 1) : '1;
         logic [IN_W+OUT_W-1:0] ext;

         assign ext = (IN_W + OUT_W)'(value);

         // result is a plain mask of the low bits
         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff <= ext[OUT_W-1:0] & MASK;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff <= 1'b0;
            end else if (start) begin
               vld_ff <= 1'b1;
            end
         end
      end else begin : g_serial
         localparam int ND    = (IN_W + 3) / 4;
         localparam int PAD_W = ND * 4;
         localparam int RW    = OUT_W + 5;
         localparam int CNT_W = $clog2(ND + 1);
         localparam logic [RW-1:0] MOD_R = RW'(MOD);

         logic [PAD_W-1:0] val_ff;
         logic [CNT_W-1:0] cnt_ff;
         logic [OUT_W-1:0] rem_in;

         // one digit: shift in, then restoring subtract of 8N, 4N, 2N, N
         always_comb begin
            logic [RW-1:0] t;
            t = (RW'(rem_ff) << 4) | RW'(val_ff[PAD_W-1 -: 4]);
            for (int k = 3; k >= 0; k--) begin
               if (t >= (MOD_R << k)) begin
                  t = t - (MOD_R << k);
               end
            end
            rem_in = t[OUT_W-1:0];
         end

         always_ff @(posedge clock) begin
            if (start) begin
               val_ff <= PAD_W'(value);
               rem_ff <= '0;
            end else if (cnt_ff != '0) begin
               val_ff <= val_ff << 4;
               rem_ff <= rem_in;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               cnt_ff <= '0;
               vld_ff <= 1'b0;
            end else if (start) begin
               cnt_ff <= CNT_W'(ND);
               vld_ff <= 1'b0;
            end else if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  vld_ff <= 1'b1;
               end
            end
         end
      end
   endgenerate

endmodule

// ===== rtl/srrip_sig_table.sv =====
// ----------------------------------------------------------------------------
// srrip_sig_table
// Reuse counter table: one 2-bit saturating counter per PC signature, in a
// synchronous memory. Trains the evicted line's counter and reads the new
// signature's counter, forwarding when both signatures match.
// ----------------------------------------------------------------------------
module srrip_sig_table import srrip_pkg::*; #(
   parameter int SIG_ENTRIES = 256,
   parameter int SIG_W       = $clog2(SIG_ENTRIES)
) (
   input  logic              clock,
   input  ctr_cmd_type       cmd,
   input  logic [SIG_W-1:0]  clr_addr,
   input  logic [SIG_W-1:0]  old_sig,
   input  logic [SIG_W-1:0]  new_sig,
   output logic [1:0]        ctr_val
);

   logic [1:0]       ctr_mem [SIG_ENTRIES];
   logic [1:0]       rd_ff;
   logic [1:0]       trained;
   logic [1:0]       trained_ff;
   logic             fwd_ff;
   logic             wr_en;
   logic [SIG_W-1:0] wr_addr;
   logic [1:0]       wr_data;
   logic             rd_en;
   logic [SIG_W-1:0] rd_addr;

   // saturating train of the evicted line's counter
   always_comb begin
      trained = rd_ff;
      if (cmd.train_up) begin
         if (rd_ff != CTR_MAX) begin
            trained = rd_ff + 2'd1;
         end
      end else if (rd_ff != 2'd0) begin
         trained = rd_ff - 2'd1;
      end
   end

   // port control
   assign wr_en   = cmd.clear | cmd.train;
   assign wr_addr = cmd.clear ? clr_addr : old_sig;
   assign wr_data = cmd.clear ? 2'd0 : trained;
   assign rd_en   = cmd.rd_old | cmd.train;
   assign rd_addr = cmd.train ? new_sig : old_sig;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ctr_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= ctr_mem[rd_addr];
      end
   end

   // read of the counter being written in the same cycle takes the new value
   always_ff @(posedge clock) begin
      if (cmd.train) begin
         fwd_ff     <= (new_sig == old_sig);
         trained_ff <= trained;
      end
   end

   assign ctr_val = fwd_ff ? trained_ff : rd_ff;

endmodule

// ===== rtl/ship_srrip_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// ship_srrip_replacement_unit
// SRRIP replacement with a SHiP signature reuse predictor.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream. tuser says what the transfer is: a
// victim request or a state update (hit promotion or miss fill). A victim
// request returns one transfer on the rsp_ stream with the chosen way; an
// update returns nothing. csr_ writes the insertion value used for
// signatures whose counter is one; it is always ready.
// Per-set metadata (rrpv, signature, reused flag of every way) sits in one
// synchronous memory row per set; the reuse counters sit in a second memory.
// A victim request or hit passes through accept, set read and write back
// before the next ready; a miss fill adds the counter read, train and
// install. A modulus that is not a power of two and lies below the field's
// range is reduced one hex digit per cycle and lengthens the reduce step;
// both reductions run in parallel, so the slower one sets the delay.
// After reset a clearing pass writes one set row and one counter per cycle,
// until every set row and counter is cleared, with req_tready low.
// A stalled rsp_ register does not block acceptance; only the write back of
// a later victim request waits for the register to drain.
// ----------------------------------------------------------------------------
module ship_srrip_replacement_unit import srrip_pkg::*; #(
   parameter int NUM_SETS    = 2048,
   parameter int NUM_WAYS    = 16,
   parameter int SIG_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // set_index[10:0], way_index[14:11], pc[78:15], 0
   input  logic [1:0]  req_tuser,   // func[0], hit[1]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // victim_way[3:0], 0
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_wdata    // medium_insert_rrpv[1:0]
);

   localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int SIG_W  = $clog2(SIG_ENTRIES);
   localparam int WAY_W  = $clog2(NUM_WAYS);
   localparam int ROW_W  = NUM_WAYS * (3 + SIG_W);
   localparam int CLR_N  = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
   localparam int CLR_W  = $clog2(CLR_N + 1);
   localparam logic [CLR_W-1:0]  CLR_LAST    = CLR_W'(CLR_N - 1);
   localparam logic [CLR_W-1:0]  CLR_SETS    = CLR_W'(NUM_SETS);
   localparam logic [CLR_W-1:0]  CLR_SIGS    = CLR_W'(SIG_ENTRIES);
   localparam logic [5:0]        NUM_WAYS_C  = 6'(NUM_WAYS);
   localparam logic [SET_AW:0]   NUM_SETS_C  = (SET_AW + 1)'(NUM_SETS);

   // ---------------------------------------------------------------- fields
   logic        req_func;
   logic        req_hit;
   logic [10:0] req_set;
   logic [3:0]  req_way;
   logic [63:0] req_pc;
   logic [63:0] req_hash;
   logic        req_accept;
   logic        req_drop;

   assign req_func = req_tuser[0];
   assign req_hit  = req_tuser[1];
   assign req_set  = req_tdata[10:0];
   assign req_way  = req_tdata[14:11];
   assign req_pc   = req_tdata[78:15];
   assign req_hash = req_pc ^ (req_pc >> HASH_SHIFT_A) ^ (req_pc >> HASH_SHIFT_B);

   assign req_accept = req_tvalid & req_tready;
   // update of a way beyond the set changes nothing
   assign req_drop   = (req_func == FUNC_UPDATE) && ({2'b00, req_way} >= NUM_WAYS_C);

   // ------------------------------------------------------- request capture
   logic             func_ff;
   logic             hit_ff;
   logic [WAY_W-1:0] way_ff;
   logic [WAY_W+3:0] way_ext;

   assign way_ext = (WAY_W + 4)'(req_way);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= req_func;
         hit_ff  <= req_hit;
         way_ff  <= way_ext[WAY_W-1:0];
      end
   end

   // --------------------------------------------------- set and sig reduce
   logic [SET_AW-1:0] set_rem;
   logic              set_done;
   logic [SIG_W-1:0]  sig_rem;
   logic              sig_done;

   srrip_mod_unit #(
      .IN_W  (11),
      .MOD   (NUM_SETS),
      .OUT_W (SET_AW)
   ) u_set_mod (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .value (req_set),
      .rem   (set_rem),
      .done  (set_done)
   );

   srrip_mod_unit #(
      .IN_W  (64),
      .MOD   (SIG_ENTRIES),
      .OUT_W (SIG_W)
   ) u_sig_mod (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .value (req_hash),
      .rem   (sig_rem),
      .done  (sig_done)
   );

   // ---------------------------------------------------------- config reg
   logic [1:0] medium_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         medium_ff <= MEDIUM_RESET;
      end else if (csr_valid & csr_ready) begin
         medium_ff <= csr_wdata;
      end
   end

   // ------------------------------------------------------- set metadata
   logic [ROW_W-1:0]  set_mem [NUM_SETS];
   logic [ROW_W-1:0]  set_rd_ff;
   logic              set_rd_en;
   logic              set_wr_en;
   logic [SET_AW-1:0] set_wr_addr;
   logic [ROW_W-1:0]  set_wr_data;

   always_ff @(posedge clock) begin
      if (set_wr_en) begin
         set_mem[set_wr_addr] <= set_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (set_rd_en) begin
         set_rd_ff <= set_mem[set_rem];
      end
   end

   logic [NUM_WAYS-1:0][1:0]       cur_rrpv;
   logic [NUM_WAYS-1:0][SIG_W-1:0] cur_sigs;
   logic [NUM_WAYS-1:0]            cur_reused;

   assign {cur_reused, cur_sigs, cur_rrpv} = set_rd_ff;

   // ------------------------------------------------ aging and victim pick
   logic [1:0]               top_rrpv;
   logic [1:0]               age_add;
   logic [NUM_WAYS-1:0][1:0] aged_rrpv;
   logic [WAY_W-1:0]         victim;
   logic [WAY_W+3:0]         victim_ext;

   // largest rrpv of the set, built bit by bit
   always_comb begin
      logic hi_any;
      logic lo_hi;
      logic lo_lo;
      hi_any = 1'b0;
      lo_hi  = 1'b0;
      lo_lo  = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         hi_any = hi_any | cur_rrpv[w][1];
         lo_hi  = lo_hi | (cur_rrpv[w] == 2'd3);
         lo_lo  = lo_lo | (cur_rrpv[w] == 2'd1);
      end
      top_rrpv = {hi_any, hi_any ? lo_hi : lo_lo};
   end

   assign age_add = RRPV_MAX - top_rrpv;

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged_rrpv[w] = cur_rrpv[w] + age_add;
      end
   end

   // lowest way holding the largest value
   always_comb begin
      victim = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (cur_rrpv[w] == top_rrpv) begin
            victim = WAY_W'(w);
         end
      end
   end

   assign victim_ext = (WAY_W + 4)'(victim);

   // --------------------------------------------------- counter table
   ctr_cmd_type      ctr_cmd;
   logic [SIG_W-1:0] old_sig;
   logic [1:0]       ctr_val;
   logic [1:0]       ins_rrpv;
   logic [CLR_W-1:0] clr_ff;

   assign old_sig = cur_sigs[way_ff];

   srrip_sig_table #(
      .SIG_ENTRIES (SIG_ENTRIES),
      .SIG_W       (SIG_W)
   ) u_sig_table (
      .clock    (clock),
      .cmd      (ctr_cmd),
      .clr_addr (clr_ff[SIG_W-1:0]),
      .old_sig  (old_sig),
      .new_sig  (sig_rem),
      .ctr_val  (ctr_val)
   );

   // insertion value from the new signature's counter
   always_comb begin
      if (ctr_val >= CTR_STRONG) begin
         ins_rrpv = 2'd0;
      end else if (ctr_val == 2'd1) begin
         ins_rrpv = medium_ff;
      end else begin
         ins_rrpv = RRPV_MAX;
      end
   end

   // -------------------------------------------------------- sequencer
   state_type state_ff;
   state_type state_in;
   logic      rsp_free;
   logic      rsp_load;

   assign rsp_free = !rsp_tvalid || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && !req_drop) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (set_done && sig_done) begin
               state_in = ST_SET;
            end
         end
         ST_SET: begin
            if (func_ff == FUNC_VICTIM) begin
               if (rsp_free) begin
                  state_in = ST_IDLE;
               end
            end else if (hit_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_TRAIN;
            end
         end
         ST_TRAIN:   state_in = ST_INSTALL;
         ST_INSTALL: state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   // outputs and memory commands
   always_comb begin
      logic [NUM_WAYS-1:0][1:0]       wr_rrpv;
      logic [NUM_WAYS-1:0][SIG_W-1:0] wr_sigs;
      logic [NUM_WAYS-1:0]            wr_reused;
      wr_rrpv     = cur_rrpv;
      wr_sigs     = cur_sigs;
      wr_reused   = cur_reused;
      req_tready  = 1'b0;
      set_rd_en   = 1'b0;
      set_wr_en   = 1'b0;
      set_wr_addr = set_rem;
      rsp_load    = 1'b0;
      ctr_cmd     = '0;
      case (state_ff)
         ST_CLEAR: begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               wr_rrpv[w] = RRPV_MAX;
            end
            wr_sigs       = '0;
            wr_reused     = '0;
            set_wr_addr   = clr_ff[SET_AW-1:0];
            set_wr_en     = (clr_ff < CLR_SETS);
            ctr_cmd.clear = (clr_ff < CLR_SIGS);
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_REDUCE: begin
            set_rd_en = set_done && sig_done;
         end
         ST_SET: begin
            if (func_ff == FUNC_VICTIM) begin
               wr_rrpv   = aged_rrpv;
               set_wr_en = rsp_free;
               rsp_load  = rsp_free;
            end else if (hit_ff) begin
               wr_rrpv[way_ff]   = 2'd0;
               wr_reused[way_ff] = 1'b1;
               set_wr_en         = 1'b1;
            end else begin
               ctr_cmd.rd_old = 1'b1;
            end
         end
         ST_TRAIN: begin
            ctr_cmd.train    = 1'b1;
            ctr_cmd.train_up = cur_reused[way_ff];
         end
         ST_INSTALL: begin
            wr_rrpv[way_ff]   = ins_rrpv;
            wr_sigs[way_ff]   = sig_rem;
            wr_reused[way_ff] = 1'b0;
            set_wr_en         = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      set_wr_data = {wr_reused, wr_sigs, wr_rrpv};
   end

   // clearing sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (state_ff == ST_CLEAR) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // ------------------------------------------------------ response reg
   logic       rsp_tvalid_ff;
   logic       rsp_tvalid_in;
   logic [3:0] rsp_way_ff;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_way_ff <= victim_ext[3:0];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0000, rsp_way_ff};

   // ------------------------------------------------------- assertions
   // chosen victim holds the largest value after aging
   a_victim_max: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (aged_rrpv[victim] == RRPV_MAX))
      else $error("victim way does not hold the maximum rrpv");

   // counters only train on a miss fill
   a_train_miss: assert property (@(posedge clock) disable iff (reset)
      ctr_cmd.train |-> ((func_ff == FUNC_UPDATE) && !hit_ff))
      else $error("counter trained outside a miss fill");

   // reduced set stays inside the memory
   a_set_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SET) |-> ({1'b0, set_rem} < NUM_SETS_C))
      else $error("set index out of range");

   // set memory never read and written in one cycle
   a_set_port: assert property (@(posedge clock) disable iff (reset)
      set_wr_en |-> !set_rd_en)
      else $error("set memory read and write overlap");

   // a miss fill always goes through training before install
   a_install_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSTALL) |-> ($past(state_ff) == ST_TRAIN))
      else $error("install without counter training");

endmodule
